// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the symbol former.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off while reset is high.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle, off while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rlsf_pkg.sv =====
// Shared types and constants of the run-length symbol former.
package rlsf_pkg;

  // Block and predictor geometry
  localparam int BLOCK_COEFS = 64;
  localparam int COMPONENTS  = 3;
  localparam int POS_W       = $clog2(BLOCK_COEFS);
  localparam int COMP_IDX_W  = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  // Field widths
  localparam int COEF_W  = 12;
  localparam int COMP_W  = 2;
  localparam int VALUE_W = COEF_W + 1;
  localparam int RUN_W   = 4;
  localparam int SIZE_W  = 4;
  localparam int AMP_W   = 12;
  localparam int PEND_W  = 6;
  localparam int R16_W   = PEND_W - RUN_W;

  // Zero-run constants
  localparam logic [PEND_W-1:0] MAX_PENDING = PEND_W'(63);
  localparam logic [RUN_W-1:0]  RUN16_CODE  = RUN_W'(15);

  // Symbol queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified item: what the back needs to emit its symbols
  typedef struct packed {
    logic                      is_dc;
    logic signed [VALUE_W-1:0] value;
    logic [R16_W-1:0]          run16s;
    logic [RUN_W-1:0]          run;
    logic                      eob;
  } rlsf_entry_t;

  // Bit length of a magnitude
  function automatic logic [SIZE_W-1:0] size_of(input logic [VALUE_W-1:0] mag);
    logic [SIZE_W-1:0] s;
    s = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (mag[i]) s = SIZE_W'(i + 1);
    end
    return s;
  endfunction

endpackage

// ===== design/rlsf_front.sv =====
// Front end: accepts coefficients, tracks position, DC predictors and zero count.
module rlsf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rlsf_pkg::COEF_W-1:0] coefficient,
  input  logic [rlsf_pkg::COMP_W-1:0]       component,
  input  logic                              queue_full,
  output logic                              push,
  output rlsf_pkg::rlsf_entry_t             entry
);
  import rlsf_pkg::*;

  logic signed [COEF_W-1:0] previous_dc [COMPONENTS];
  logic [POS_W-1:0]         position;
  logic [PEND_W-1:0]        pending_zeros;

  logic                      accept;
  logic                      last_pos;
  logic                      at_dc;
  logic                      coef_zero;
  logic                      comp_ok;
  logic [COMP_IDX_W-1:0]     comp_idx;
  logic signed [COEF_W-1:0]  pred;
  logic signed [VALUE_W-1:0] diff;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign last_pos  = (position == POS_W'(BLOCK_COEFS - 1));
  assign at_dc     = (position == '0);
  assign coef_zero = (coefficient == '0);
  assign comp_ok   = (int'(component) < COMPONENTS);
  assign comp_idx  = component[COMP_IDX_W-1:0];
  assign pred      = comp_ok ? previous_dc[comp_idx] : '0;
  assign diff      = VALUE_W'(coefficient) - VALUE_W'(pred);

  // Classify the item; a zero AC coefficient before the last position emits nothing
  always_comb begin
    entry        = '0;
    entry.is_dc  = at_dc;
    entry.eob    = last_pos;
    if (at_dc) begin
      entry.value = diff;
    end else if (!coef_zero) begin
      entry.value  = VALUE_W'(coefficient);
      entry.run16s = pending_zeros[PEND_W-1:RUN_W];
      entry.run    = pending_zeros[RUN_W-1:0];
    end
    push = accept && (at_dc || !coef_zero || last_pos);
  end

  // Advance position, zero count and predictors
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      pending_zeros <= '0;
      for (int i = 0; i < COMPONENTS; i++) previous_dc[i] <= '0;
    end else if (accept) begin
      position <= last_pos ? '0 : position + POS_W'(1);
      if (at_dc) begin
        pending_zeros <= '0;
        if (comp_ok) previous_dc[comp_idx] <= coefficient;
      end else if (coef_zero && !last_pos) begin
        if (pending_zeros != MAX_PENDING) pending_zeros <= pending_zeros + PEND_W'(1);
      end else begin
        pending_zeros <= '0;
      end
    end
  end

endmodule

// ===== design/rlsf_queue.sv =====
// Short queue of classified items between front and back.
module rlsf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rlsf_pkg::rlsf_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output rlsf_pkg::rlsf_entry_t head_entry
);
  import rlsf_pkg::*;

  rlsf_entry_t          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;
  logic                 do_pop;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_entry;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_pop)        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({push && !full, do_pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/rlsf_back.sv =====
// Back end: expands queued items into run-16 and coded symbols.
module rlsf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  rlsf_pkg::rlsf_entry_t       head_entry,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_dc,
  output logic [rlsf_pkg::RUN_W-1:0]  zero_run,
  output logic [rlsf_pkg::SIZE_W-1:0] size_category,
  output logic [rlsf_pkg::AMP_W-1:0]  amplitude_bits,
  output logic                        end_of_block,
  output logic                        last_of_item
);
  import rlsf_pkg::*;

  logic [R16_W-1:0]   sub_count;
  logic               out_load;
  logic               emit;
  logic               final_sym;
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [SIZE_W-1:0]  size;
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] amp_full;

  assign out_load  = !out_valid || out_ready;
  assign emit      = head_valid && out_load;
  assign final_sym = (sub_count == head_entry.run16s);
  assign pop       = emit && final_sym;

  // Size category and ones'-complement amplitude of the value
  assign neg      = head_entry.value[VALUE_W-1];
  assign mag      = neg ? VALUE_W'(-head_entry.value) : VALUE_W'(head_entry.value);
  assign size     = size_of(mag);
  assign mask     = (VALUE_W'(1) << size) - VALUE_W'(1);
  assign amp_full = neg ? ((VALUE_W'(head_entry.value) - VALUE_W'(1)) & mask)
                        : VALUE_W'(head_entry.value);

  // Count run-16 symbols of the head item
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_count <= '0;
    end else if (emit) begin
      sub_count <= final_sym ? '0 : sub_count + R16_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (final_sym) begin
        is_dc          <= head_entry.is_dc;
        zero_run       <= head_entry.run;
        size_category  <= size;
        amplitude_bits <= amp_full[AMP_W-1:0];
        end_of_block   <= head_entry.eob;
        last_of_item   <= 1'b1;
      end else begin
        is_dc          <= 1'b0;
        zero_run       <= RUN16_CODE;
        size_category  <= '0;
        amplitude_bits <= '0;
        end_of_block   <= 1'b0;
        last_of_item   <= 1'b0;
      end
    end
  end

endmodule

// ===== design/jpeg_run_length_symbol_former.sv =====
// Top level of the JPEG baseline zero run-length symbol former.
// The first symbol of an item is stored in a queue slot and then in the output register
// before it can transfer out. Throughput: one coefficient per cycle in while the queue is
// not full; one symbol per cycle out while m_axis_tready is high. Each run-16 symbol of an
// item holds the output for one more symbol; a 4-entry queue absorbs it. Reset (rst,
// synchronous) clears the DC predictors, position, zero count, the queue and the output valid.
module jpeg_run_length_symbol_former (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] coefficient, [15:12] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] component
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] zero_run, [7:4] size_category,
                                      // [19:8] amplitude_bits, [20] last_of_item, [23:21] zero
  output logic [0:0]  m_axis_tuser,   // [0] is_dc
  output logic        m_axis_tlast    // end_of_block
);
  import rlsf_pkg::*;

  rlsf_entry_t       push_entry;
  rlsf_entry_t       head_entry;
  logic              push;
  logic              full;
  logic              pop;
  logic              head_valid;
  logic              is_dc;
  logic [RUN_W-1:0]  zero_run;
  logic [SIZE_W-1:0] size_category;
  logic [AMP_W-1:0]  amplitude_bits;
  logic              end_of_block;
  logic              last_of_item;

  rlsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .coefficient (s_axis_tdata[COEF_W-1:0]),
    .component   (s_axis_tuser),
    .queue_full  (full),
    .push        (push),
    .entry       (push_entry)
  );

  rlsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  rlsf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .is_dc          (is_dc),
    .zero_run       (zero_run),
    .size_category  (size_category),
    .amplitude_bits (amplitude_bits),
    .end_of_block   (end_of_block),
    .last_of_item   (last_of_item)
  );

  // Pack the output transfer
  assign m_axis_tdata = {3'b000, last_of_item, amplitude_bits, size_category, zero_run};
  assign m_axis_tuser = is_dc;
  assign m_axis_tlast = end_of_block;

endmodule

// ===== design/rlsf_checker.sv =====
// Port-level checks of the symbol former and their binding to the top level.
`include "assert_macros.svh"

module rlsf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Stalled output holds its symbol
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output symbol changed while stalled")

  // An AC symbol of size zero that does not end the block is a run-16 symbol
  `ASSERT_SAME(a_run16_shape, m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tlast && m_axis_tdata[7:4] == 4'd0, m_axis_tdata[3:0] == 4'd15 && m_axis_tdata[19:8] == 12'd0 && !m_axis_tdata[20], "malformed run-16 symbol")

  // A DC symbol has no zero run and ends its item
  `ASSERT_SAME(a_dc_shape, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[20], "malformed DC symbol")

  // The end of a block is always the last symbol of its item
  `ASSERT_SAME(a_eob_last, m_axis_tvalid && m_axis_tlast, m_axis_tdata[20], "end of block before last symbol of item")

endmodule

bind jpeg_run_length_symbol_former rlsf_checker u_rlsf_checker (.*);
